>>> hw/rtl/slbs_pkg.sv
// Package for the status LED blink sequencer.
// Holds the status and pattern types, colour codes and tick constants.
// Depends on nothing; used by every module of the block.
package slbs_pkg;

    typedef enum logic [1:0] {
        COLOUR_NONE   = 2'd0,
        COLOUR_RED    = 2'd1,
        COLOUR_GREEN  = 2'd2,
        COLOUR_YELLOW = 2'd3
    } colour_t;

    localparam logic [7:0] IDLE_OFF_TICKS = 8'd40;
    localparam logic [7:0] SHORT_TICKS    = 8'd10;
    localparam logic [7:0] LONG_TICKS     = 8'd50;

    localparam int unsigned STATUS_W = 9;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 8;

    typedef struct packed {
        logic below_quarter;
        logic above_quarter;
        logic charging;
        logic capacity_full;
        logic overcurrent;
        logic charger_overtemp;
        logic battery_overvoltage;
        logic mains_fault;
        logic idle;
    } status_t;

    typedef struct packed {
        colour_t    colour;
        logic [7:0] on_ticks;
        logic [7:0] off_ticks;
    } pattern_t;

    typedef struct packed {
        logic green_level;
        logic red_level;
    } levels_t;

endpackage

>>> hw/rtl/slbs_pattern_sel.sv
// Priority selection of a blink pattern from the charger status bits.
// Depends on slbs_pkg for the status and pattern types.
module slbs_pattern_sel
(
    input  slbs_pkg::status_t  status,
    output slbs_pkg::pattern_t pattern,
    output logic               hit
);

    logic fault;

    assign fault = status.mains_fault | status.battery_overvoltage |
                   status.charger_overtemp | status.overcurrent;

    always_comb
    begin
        hit     = 1'b1;
        pattern = '{slbs_pkg::COLOUR_NONE, 8'd0, 8'd0};
        if (status.idle)
        begin
            pattern = '{slbs_pkg::COLOUR_GREEN, 8'd0, slbs_pkg::IDLE_OFF_TICKS};
        end
        else if (fault)
        begin
            pattern = '{slbs_pkg::COLOUR_RED, slbs_pkg::SHORT_TICKS, 8'd0};
        end
        else if (status.capacity_full)
        begin
            pattern = '{slbs_pkg::COLOUR_GREEN, slbs_pkg::SHORT_TICKS, 8'd0};
        end
        else if (status.charging)
        begin
            pattern = '{slbs_pkg::COLOUR_GREEN, slbs_pkg::LONG_TICKS,
                        slbs_pkg::LONG_TICKS};
        end
        else if (status.above_quarter)
        begin
            pattern = '{slbs_pkg::COLOUR_GREEN, slbs_pkg::SHORT_TICKS,
                        slbs_pkg::SHORT_TICKS};
        end
        else if (status.below_quarter)
        begin
            pattern = '{slbs_pkg::COLOUR_RED, slbs_pkg::SHORT_TICKS,
                        slbs_pkg::SHORT_TICKS};
        end
        else
        begin
            hit = 1'b0;
        end
    end

endmodule

>>> hw/rtl/slbs_blinker.sv
// Blink state: the held pattern, on/off/repeat counters and pin levels.
// Advances one tick per step; uses slbs_pattern_sel and slbs_pkg.
module slbs_blinker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  slbs_pkg::status_t  status,
    output slbs_pkg::levels_t  levels_next
);

    slbs_pkg::pattern_t sel_pattern;
    logic               sel_hit;

    slbs_pkg::pattern_t pattern_reg;
    slbs_pkg::pattern_t pattern_next;
    logic [7:0]         on_left_reg;
    logic [7:0]         on_left_next;
    logic [7:0]         off_left_reg;
    logic [7:0]         off_left_next;
    logic               repeats_left_reg;
    logic               repeats_left_next;
    logic               red_pin_reg;
    logic               green_pin_reg;

    logic [7:0]         on_cur;
    logic [7:0]         off_cur;
    logic               rep_cur;

    slbs_pattern_sel u_sel
    (
        .status  (status),
        .pattern (sel_pattern),
        .hit     (sel_hit)
    );

    always_comb
    begin
        if (!repeats_left_reg)
        begin
            pattern_next = sel_hit ? sel_pattern : pattern_reg;
            on_cur       = pattern_next.on_ticks;
            off_cur      = pattern_next.off_ticks;
            rep_cur      = 1'b1;
        end
        else
        begin
            pattern_next = pattern_reg;
            on_cur       = on_left_reg;
            off_cur      = off_left_reg;
            rep_cur      = repeats_left_reg;
        end

        levels_next.red_level   = red_pin_reg;
        levels_next.green_level = green_pin_reg;
        on_left_next            = on_cur;
        off_left_next           = off_cur;
        repeats_left_next       = rep_cur;

        if (on_cur != 8'd0)
        begin
            case (pattern_next.colour)
                slbs_pkg::COLOUR_RED:
                begin
                    levels_next.red_level   = 1'b1;
                    levels_next.green_level = 1'b0;
                end
                slbs_pkg::COLOUR_GREEN:
                begin
                    levels_next.red_level   = 1'b0;
                    levels_next.green_level = 1'b1;
                end
                slbs_pkg::COLOUR_YELLOW:
                begin
                    levels_next.red_level   = 1'b1;
                    levels_next.green_level = 1'b1;
                end
                default:
                begin
                end
            endcase
            on_left_next = on_cur - 8'd1;
        end
        else if (off_cur != 8'd0)
        begin
            levels_next.red_level   = 1'b0;
            levels_next.green_level = 1'b0;
            off_left_next           = off_cur - 8'd1;
        end
        else if (rep_cur)
        begin
            on_left_next      = pattern_next.on_ticks;
            off_left_next     = pattern_next.off_ticks;
            repeats_left_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg      <= '{slbs_pkg::COLOUR_NONE, 8'd0, 8'd0};
            on_left_reg      <= 8'd0;
            off_left_reg     <= 8'd0;
            repeats_left_reg <= 1'b0;
            red_pin_reg      <= 1'b0;
            green_pin_reg    <= 1'b0;
        end
        else if (step)
        begin
            pattern_reg      <= pattern_next;
            on_left_reg      <= on_left_next;
            off_left_reg     <= off_left_next;
            repeats_left_reg <= repeats_left_next;
            red_pin_reg      <= levels_next.red_level;
            green_pin_reg    <= levels_next.green_level;
        end
    end

    // The selectable patterns never light both pins at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(red_pin_reg && green_pin_reg))
        else $error("both LED pins driven high");

    // The working counters never run past the pattern they came from.
    assert property (@(posedge clk) disable iff (!rst_n)
        on_left_reg <= pattern_reg.on_ticks)
        else $error("on counter exceeds pattern on ticks");

    assert property (@(posedge clk) disable iff (!rst_n)
        off_left_reg <= pattern_reg.off_ticks)
        else $error("off counter exceeds pattern off ticks");

    // Without a step the blink state holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(on_left_reg) && $stable(off_left_reg) &&
                  $stable(repeats_left_reg))
        else $error("blink state moved without a step");

endmodule

>>> hw/rtl/status_led_blink_sequencer_core.sv
// Top level of the status LED blink sequencer: input word register,
// blink state and result register. Uses slbs_blinker and slbs_pkg.
//
// Channel | Dir | Word contents (lowest bit first)
// s_*     | in  | idle, mains_fault, battery_overvoltage, charger_overtemp,
//         |     | overcurrent, capacity_full, charging, above_quarter,
//         |     | below_quarter, zero fill to 16 bits
// m_*     | out | red_level, green_level, zero fill to 8 bits
//
// One status word gives one result word; the blink counters step once per word.
// A new word is taken every cycle while m_tready does not stall the result.
// Reset clears the blink state and both pipeline valid flags.
// A stall on m_tready holds the result and backs up the input register.
module status_led_blink_sequencer_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata bits 0..8: idle, mains_fault, battery_overvoltage, charger_overtemp,
    // overcurrent, capacity_full, charging, above_quarter, below_quarter.
    input  logic [slbs_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata bits 0..1: red_level, green_level.
    output logic [slbs_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic              in_valid_reg;
    slbs_pkg::status_t in_status_reg;
    logic              out_valid_reg;
    slbs_pkg::levels_t out_levels_reg;
    slbs_pkg::levels_t levels_next;
    logic              advance;
    logic              step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    slbs_blinker u_blinker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .status      (in_status_reg),
        .levels_next (levels_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_status_reg <= slbs_pkg::status_t'(s_tdata[slbs_pkg::STATUS_W-1:0]);
        end
        if (step)
        begin
            out_levels_reg <= levels_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(slbs_pkg::M_TDATA_W - 2){1'b0}},
                       out_levels_reg.green_level, out_levels_reg.red_level};

    // An empty result register always lets a new word in.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // A word in the input register that steps shows up as a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("stepped word did not reach the result register");

    // A held result blocks the input register from advancing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !step)
        else $error("blink state stepped while the result was stalled");

endmodule
